// ----- src/whug_pkg.sv -----
// Shared types and constants for the Wichmann-Hill uniform generator.
package whug_pkg;

    localparam int NUM_GEN   = 3;
    localparam int RES_W     = 15;
    localparam int MUL_W     = 8;
    localparam int PROD_W    = RES_W + MUL_W;
    localparam int QUO_W     = 8;
    localparam int REM_W     = RES_W + 1;
    localparam int RECIP_SH  = 38;
    localparam int RECIP_W   = 24;
    localparam int QP_W      = PROD_W + RECIP_W;
    localparam int FRAC_W    = 32;
    localparam int FRAC_SH   = 30;
    localparam int FRAC_KW   = 48;
    localparam int KSPLIT    = 24;
    localparam int KH_W      = FRAC_KW - KSPLIT;
    localparam int PP_W      = RES_W + KSPLIT;
    localparam int FULL_W    = PP_W + KSPLIT;
    localparam int CFG_IDX_W = 2;
    localparam int RQ_DEPTH  = 4;
    localparam int RQ_AW     = $clog2(RQ_DEPTH);
    localparam int OB_DEPTH  = 2;
    localparam int OB_AW     = $clog2(OB_DEPTH);

    localparam int MOD_X = 30269;
    localparam int MOD_Y = 30307;
    localparam int MOD_Z = 30323;

    localparam logic [63:0] ONE64 = 64'd1;

    localparam logic [RES_W-1:0] MODULUS [NUM_GEN] = '{
        RES_W'(MOD_X), RES_W'(MOD_Y), RES_W'(MOD_Z)};
    localparam logic [MUL_W-1:0] MULT [NUM_GEN] = '{8'd171, 8'd172, 8'd170};
    localparam logic [RES_W-1:0] SEED_RST [NUM_GEN] = '{15'd13, 15'd37, 15'd91};

    // floor(2^38 / m): quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP [NUM_GEN] = '{
        RECIP_W'((ONE64 << RECIP_SH) / 64'(MOD_X)),
        RECIP_W'((ONE64 << RECIP_SH) / 64'(MOD_Y)),
        RECIP_W'((ONE64 << RECIP_SH) / 64'(MOD_Z))};

    // ceil(2^62 / m): (r * K) >> 30 equals floor(r * 2^32 / m) for r < m
    localparam logic [FRAC_KW-1:0] FRAC_K [NUM_GEN] = '{
        FRAC_KW'(((ONE64 << (FRAC_W + FRAC_SH)) + 64'(MOD_X) - ONE64) / 64'(MOD_X)),
        FRAC_KW'(((ONE64 << (FRAC_W + FRAC_SH)) + 64'(MOD_Y) - ONE64) / 64'(MOD_Y)),
        FRAC_KW'(((ONE64 << (FRAC_W + FRAC_SH)) + 64'(MOD_Z) - ONE64) / 64'(MOD_Z))};

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_Z = 2'd2;

    // lane 0 = x, 1 = y, 2 = z
    typedef logic [NUM_GEN-1:0][RES_W-1:0] t_resid;

    typedef struct packed {
        logic   push;
        t_resid data;
    } t_rq_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_rq_stat;

endpackage

// ----- src/wichmann_hill_uniform_generator_unit.sv -----
// Wichmann-Hill uniform generator: top level.
// The front end accepts no new push until its residue step (constant multiply,
// reciprocal quotient, subtract and correct) has written its word into the residue queue.
// Sync active-low reset: seeds 13/37/91, residues equal to the seeds, both queues empty.
module wichmann_hill_uniform_generator_unit import whug_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_restart,
    output logic                 empty,
    input  logic                 pop,
    output logic [FRAC_W-1:0]    o_uniform_fraction,
    output logic [RES_W-1:0]     o_residue_x,
    output logic [RES_W-1:0]     o_residue_y,
    output logic [RES_W-1:0]     o_residue_z,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RES_W-1:0]     i_cfg_data
);

    t_rq_wr   q_wr;
    t_rq_stat q_stat;
    t_resid   q_data;
    logic     q_pop;
    t_resid   out_res;

    whug_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_restart   (i_restart),
        .o_full      (full),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_q_wr      (q_wr)
    );

    whug_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_data  (q_data)
    );

    whug_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_fraction (o_uniform_fraction),
        .o_res      (out_res)
    );

    assign o_residue_x = out_res[0];
    assign o_residue_y = out_res[1];
    assign o_residue_z = out_res[2];

endmodule

// ----- src/whug_front.sv -----
// Front end: seed registers, residue state and the modular step of all three generators.
module whug_front import whug_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_restart,
    output logic                 o_full,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RES_W-1:0]     i_cfg_data,
    input  t_rq_stat             i_q_stat,
    output t_rq_wr               o_q_wr
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_QUO  = 3'b010,
        S_REM  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [RES_W-1:0]    r_seed [NUM_GEN];
    logic [RES_W-1:0]    r_res  [NUM_GEN];
    logic [PROD_W-1:0]   r_prod [NUM_GEN];
    logic [QUO_W-1:0]    r_quo  [NUM_GEN];

    logic [RES_W-1:0]    operand  [NUM_GEN];
    logic [PROD_W-1:0]   n_prod   [NUM_GEN];
    logic [QP_W-1:0]     quo_prod [NUM_GEN];
    logic [QUO_W-1:0]    n_quo    [NUM_GEN];
    logic [PROD_W-1:0]   rem_wide [NUM_GEN];
    logic [REM_W-1:0]    rem_est  [NUM_GEN];
    logic [REM_W-1:0]    rem_corr [NUM_GEN];
    logic [RES_W-1:0]    rem      [NUM_GEN];
    logic                push;

    always_comb begin
        for (int g = 0; g < NUM_GEN; g++) begin
            operand[g]  = i_restart ? r_seed[g] : r_res[g];
            n_prod[g]   = PROD_W'(operand[g]) * PROD_W'(MULT[g]);
            quo_prod[g] = QP_W'(r_prod[g]) * QP_W'(RECIP[g]);
            n_quo[g]    = quo_prod[g][RECIP_SH +: QUO_W];
            rem_wide[g] = r_prod[g] - PROD_W'(r_quo[g]) * PROD_W'(MODULUS[g]);
            rem_est[g]  = rem_wide[g][REM_W-1:0];
            // estimate may be one modulus high
            if (rem_est[g] >= REM_W'(MODULUS[g])) begin
                rem_corr[g] = rem_est[g] - REM_W'(MODULUS[g]);
            end else begin
                rem_corr[g] = rem_est[g];
            end
            rem[g] = rem_corr[g][RES_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        push    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_state = S_QUO;
                end
            end
            S_QUO: begin
                n_state = S_REM;
            end
            S_REM: begin
                if (!i_q_stat.full) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_full = (r_state != S_IDLE);

    always_comb begin
        o_q_wr.push = push;
        for (int g = 0; g < NUM_GEN; g++) begin
            o_q_wr.data[g] = rem[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int g = 0; g < NUM_GEN; g++) begin
                r_seed[g] <= SEED_RST[g];
                r_res[g]  <= SEED_RST[g];
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SEED_X: r_seed[0] <= i_cfg_data;
                    CFG_SEED_Y: r_seed[1] <= i_cfg_data;
                    CFG_SEED_Z: r_seed[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                for (int g = 0; g < NUM_GEN; g++) begin
                    r_res[g] <= rem[g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NUM_GEN; g++) begin
            if (r_state == S_IDLE) begin
                r_prod[g] <= n_prod[g];
            end
            if (r_state == S_QUO) begin
                r_quo[g] <= n_quo[g];
            end
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> (o_full && r_state == S_QUO))
        else $error("front did not start a step after accepting a word");

    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (rem[0] < MODULUS[0] && rem[1] < MODULUS[1] && rem[2] < MODULUS[2]))
        else $error("reduced residue not below its modulus");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUO) |=> ($stable(r_prod[0]) && $stable(r_res[0])))
        else $error("step operands changed mid-reduction");

endmodule

// ----- src/whug_rq.sv -----
// Residue queue between the front end and the fraction back end.
module whug_rq import whug_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rq_wr   i_wr,
    input  logic     i_pop,
    output t_rq_stat o_stat,
    output t_resid   o_data
);

    t_resid             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wr_ptr;
    logic [RQ_AW-1:0]   r_rd_ptr;
    logic [RQ_AW:0]     r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_cnt == (RQ_AW+1)'(RQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_wr.push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + RQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + RQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (RQ_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (RQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (RQ_AW+1)'(RQ_DEPTH))
        else $error("residue queue count out of range");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.push |-> !o_stat.full) and (i_pop |-> !o_stat.empty))
        else $error("residue queue push while full or pop while empty");

endmodule

// ----- src/whug_back.sv -----
// Back end: Q0.32 fraction terms, their modular sum and the result buffer.
module whug_back import whug_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rq_stat          i_q_stat,
    input  t_resid            i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [FRAC_W-1:0] o_fraction,
    output t_resid            o_res
);

    logic                r_v1;
    t_resid              r_res1;
    logic [PP_W-1:0]     r_ph [NUM_GEN];
    logic [PP_W-1:0]     r_pl [NUM_GEN];
    logic                r_v2;
    t_resid              r_res2;
    logic [FRAC_W-1:0]   r_term [NUM_GEN];

    logic [FRAC_W-1:0]   r_ob_frac [OB_DEPTH];
    t_resid              r_ob_res  [OB_DEPTH];
    logic [OB_AW-1:0]    r_ob_wp;
    logic [OB_AW-1:0]    r_ob_rp;
    logic [OB_AW:0]      r_ob_cnt;

    logic                en;
    logic                ob_wr;
    logic                ob_rd;
    logic [FULL_W-1:0]   full_prod [NUM_GEN];
    logic [FRAC_W-1:0]   n_term    [NUM_GEN];
    logic [FRAC_W-1:0]   sum;

    // whole pipe holds when the last stage has nowhere to go
    assign en      = !r_v2 || (r_ob_cnt != (OB_AW+1)'(OB_DEPTH));
    assign o_q_pop = en && !i_q_stat.empty;
    assign ob_wr   = en && r_v2;
    assign o_empty = (r_ob_cnt == '0);
    assign ob_rd   = i_pop && !o_empty;

    always_comb begin
        sum = '0;
        for (int g = 0; g < NUM_GEN; g++) begin
            full_prod[g] = {r_ph[g], {KSPLIT{1'b0}}} + FULL_W'(r_pl[g]);
            n_term[g]    = full_prod[g][FRAC_SH +: FRAC_W];
            sum          = sum + r_term[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ob_wp  <= '0;
            r_ob_rp  <= '0;
            r_ob_cnt <= '0;
        end else begin
            if (en) begin
                r_v1 <= o_q_pop;
                r_v2 <= r_v1;
            end
            if (ob_wr) begin
                r_ob_wp <= r_ob_wp + OB_AW'(1);
            end
            if (ob_rd) begin
                r_ob_rp <= r_ob_rp + OB_AW'(1);
            end
            if (ob_wr && !ob_rd) begin
                r_ob_cnt <= r_ob_cnt + (OB_AW+1)'(1);
            end else if (ob_rd && !ob_wr) begin
                r_ob_cnt <= r_ob_cnt - (OB_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res1 <= i_q_data;
            r_res2 <= r_res1;
            for (int g = 0; g < NUM_GEN; g++) begin
                r_ph[g]   <= PP_W'(i_q_data[g]) * PP_W'(FRAC_K[g][FRAC_KW-1:KSPLIT]);
                r_pl[g]   <= PP_W'(i_q_data[g]) * PP_W'(FRAC_K[g][KSPLIT-1:0]);
                r_term[g] <= n_term[g];
            end
        end
        if (ob_wr) begin
            r_ob_frac[r_ob_wp] <= sum;
            r_ob_res[r_ob_wp]  <= r_res2;
        end
    end

    assign o_fraction = r_ob_frac[r_ob_rp];
    assign o_res      = r_ob_res[r_ob_rp];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en) |=> (r_v2 && $stable(r_term[0]) && $stable(r_res2)))
        else $error("stalled fraction stage lost its word");

    a_ob_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ob_wr && o_empty) |=> !o_empty)
        else $error("result written but buffer still empty");

endmodule

// ----- verif/tb_wichmann_hill_uniform_generator_unit.sv -----
// Self-checking testbench for the Wichmann-Hill uniform generator unit.
module tb_wichmann_hill_uniform_generator_unit;
    import whug_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY       = 5;
    localparam int MUL_X         = 171;
    localparam int MUL_Y         = 172;
    localparam int MUL_Z         = 170;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 250;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_PRINTS    = 40;
    localparam logic [RES_W-1:0] RES_MAX = '1;
    // no register sits at this index
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic [RES_W-1:0]  x;
        logic [RES_W-1:0]  y;
        logic [RES_W-1:0]  z;
    } t_draw;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 i_restart   = 1'b0;
    logic                 pop         = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RES_W-1:0]     i_cfg_data  = '0;
    logic                 full;
    logic                 empty;
    logic [FRAC_W-1:0]    o_uniform_fraction;
    logic [RES_W-1:0]     o_residue_x;
    logic [RES_W-1:0]     o_residue_y;
    logic [RES_W-1:0]     o_residue_z;

    wichmann_hill_uniform_generator_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_restart          (i_restart),
        .empty              (empty),
        .pop                (pop),
        .o_uniform_fraction (o_uniform_fraction),
        .o_residue_x        (o_residue_x),
        .o_residue_y        (o_residue_y),
        .o_residue_z        (o_residue_z),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // generator model state
    logic [RES_W-1:0] seed_x = 15'd13, seed_y = 15'd37, seed_z = 15'd91;
    logic [RES_W-1:0] gen_x  = 15'd13, gen_y  = 15'd37, gen_z  = 15'd91;

    logic  restart_q[$];
    t_draw expected_draws[$];
    int    mismatches = 0;
    bit    hold_wanted = 1'b0;

    function automatic logic [FRAC_W-1:0] frac_term(input logic [RES_W-1:0] r,
                                                    input int modulus);
        return FRAC_W'((64'(r) << 32) / 64'(modulus));
    endfunction

    function automatic t_draw advance_generators(input logic restart);
        t_draw d;
        if (restart) begin
            gen_x = seed_x;
            gen_y = seed_y;
            gen_z = seed_z;
        end
        gen_x = RES_W'((64'(gen_x) * MUL_X) % MOD_X);
        gen_y = RES_W'((64'(gen_y) * MUL_Y) % MOD_Y);
        gen_z = RES_W'((64'(gen_z) * MUL_Z) % MOD_Z);
        // 32-bit sum wraps, which drops the integer part
        d.fraction = frac_term(gen_x, MOD_X) + frac_term(gen_y, MOD_Y)
                   + frac_term(gen_z, MOD_Z);
        d.x = gen_x;
        d.y = gen_y;
        d.z = gen_z;
        return d;
    endfunction

    task automatic flag_mismatch(input string what, input logic [FRAC_W-1:0] got,
                                 input logic [FRAC_W-1:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s mismatch: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // acceptance side: config shadow and prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SEED_X: seed_x = i_cfg_data;
                    CFG_SEED_Y: seed_y = i_cfg_data;
                    CFG_SEED_Z: seed_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) begin
                expected_draws.push_back(advance_generators(i_restart));
                void'(restart_q.pop_front());
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_words
        t_draw want;
        if (i_rst_n && pop && !empty) begin
            if (expected_draws.size() == 0) begin
                flag_mismatch("unexpected word", o_uniform_fraction, '0);
            end else begin
                want = expected_draws.pop_front();
                if (o_uniform_fraction !== want.fraction)
                    flag_mismatch("uniform_fraction", o_uniform_fraction, want.fraction);
                if (o_residue_x !== want.x)
                    flag_mismatch("residue_x", FRAC_W'(o_residue_x), FRAC_W'(want.x));
                if (o_residue_y !== want.y)
                    flag_mismatch("residue_y", FRAC_W'(o_residue_y), FRAC_W'(want.y));
                if (o_residue_z !== want.z)
                    flag_mismatch("residue_z", FRAC_W'(o_residue_z), FRAC_W'(want.z));
            end
        end
    end

    // sender: bursts with random gaps, some bursts back to back
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || restart_q.size() == 0) begin
            push <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
        end else begin
            push      <= 1'b1;
            i_restart <= restart_q[0];
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    logic [7:0] stall_pat = 8'hFF;
    logic [2:0] pat_pos   = '0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            pop <= 1'b0;
        end else begin
            pop <= stall_pat[pat_pos];
            pat_pos++;
            if (pat_pos == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RES_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_seeds(input logic [RES_W-1:0] sx, input logic [RES_W-1:0] sy,
                               input logic [RES_W-1:0] sz);
        write_reg(CFG_SEED_X, sx);
        write_reg(CFG_SEED_Y, sy);
        write_reg(CFG_SEED_Z, sz);
    endtask

    // wait until every queued word is accepted and answered
    task automatic drain();
        while (restart_q.size() != 0 || expected_draws.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [RES_W-1:0] pick_seed(input int modulus);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        else if (sel < 3)
            return RES_W'($urandom_range(modulus, int'(RES_MAX)));
        return RES_W'($urandom_range(1, modulus - 1));
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset seeds, free running and restart
        restart_q.push_back(1'b0);
        restart_q.push_back(1'b0);
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        drain();

        // zero seeds lock every generator at zero
        write_seeds('0, '0, '0);
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        drain();

        // seeds above the modulus, all ones
        write_seeds(RES_MAX, RES_MAX, RES_MAX);
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        drain();

        // largest legal seeds
        write_seeds(RES_W'(MOD_X - 1), RES_W'(MOD_Y - 1), RES_W'(MOD_Z - 1));
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        drain();

        // seed equal to the modulus reduces to zero
        write_seeds(RES_W'(MOD_X), RES_W'(MOD_Y), RES_W'(MOD_Z));
        restart_q.push_back(1'b1);
        drain();

        write_seeds(15'd1, 15'd1, 15'd1);
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        drain();

        // writes to the unused index must change nothing
        write_seeds('0, RES_MAX, 15'd1);
        write_reg(CFG_UNUSED, RES_MAX);
        write_reg(CFG_UNUSED, 15'h2AAA);
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        restart_q.push_back(1'b1);
        drain();

        // random phases: long free-running runs, occasional restarts
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_seeds(pick_seed(MOD_X), pick_seed(MOD_Y), pick_seed(MOD_Z));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, RES_W'($urandom));
            restart_q.push_back(1'b1);
            for (int n = 1; n < PHASE_WORDS; n++)
                restart_q.push_back($urandom_range(0, 15) == 0);
            if (p == 0)
                hold_wanted = 1'b1;
            drain();
        end

        if (expected_draws.size() != 0)
            flag_mismatch("words never returned", FRAC_W'(expected_draws.size()), '0);
        if (mismatches == 0)
            $display("wichmann_hill_uniform_generator_unit regression: pass");
        else
            $display("wichmann_hill_uniform_generator_unit regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("wichmann_hill_uniform_generator_unit regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/whug_pkg.sv
src/whug_front.sv
src/whug_rq.sv
src/whug_back.sv
src/wichmann_hill_uniform_generator_unit.sv
verif/tb_wichmann_hill_uniform_generator_unit.sv
